/* hw/rtl/mdd_pkg.sv */
// Shared types and constants for the maximum drawdown tracker.
// No dependencies; compiled first.
package mdd_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DD_W        = 17;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One unit of work handed from the front end to the divider.
  typedef struct packed {
    logic [VALUE_W-1:0] peak;
    logic [VALUE_W-1:0] diff;
    logic               clear;
  } job_t;

endpackage

/* hw/rtl/mdd_in_if.sv */
// Sample channel: valid/ready handshake carrying one portfolio value.
// Depends on mdd_pkg.
interface mdd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mdd_pkg::VALUE_W-1:0] sample_value;
  logic                        series_start;

  modport source (output valid, sample_value, series_start, input ready);
  modport sink   (input valid, sample_value, series_start, output ready);
endinterface

/* hw/rtl/mdd_out_if.sv */
// Result channel: valid/ready handshake carrying current and worst drawdown.
// Depends on mdd_pkg.
interface mdd_out_if;
  logic                     valid;
  logic                     ready;
  logic [mdd_pkg::DD_W-1:0] current_drawdown;
  logic [mdd_pkg::DD_W-1:0] worst_drawdown;

  modport source (output valid, current_drawdown, worst_drawdown, input ready);
  modport sink   (input valid, current_drawdown, worst_drawdown, output ready);
endinterface

/* hw/rtl/mdd_front.sv */
// Front end: accepts samples, tracks the running peak, forms peak - value.
// Depends on mdd_pkg and mdd_in_if.
module mdd_front (
  input  logic            clk,
  input  logic            rst,
  mdd_in_if.sink          samples,
  output logic            push,
  output mdd_pkg::job_t   push_job,
  input  logic            push_ready
);
  import mdd_pkg::*;

  logic [VALUE_W-1:0] peak;
  logic [VALUE_W-1:0] peak_next;

  assign samples.ready = push_ready;
  assign push          = samples.valid && push_ready;

  always_comb begin
    peak_next = peak;
    if (samples.series_start || samples.sample_value > peak) begin
      peak_next = samples.sample_value;
    end
  end

  // value never exceeds the updated peak, so diff cannot wrap
  assign push_job.peak  = peak_next;
  assign push_job.diff  = peak_next - samples.sample_value;
  assign push_job.clear = samples.series_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (push) begin
      peak <= peak_next;
    end
  end

endmodule

/* hw/rtl/mdd_queue.sv */
// Small register FIFO between front end and divider.
// Depends on mdd_pkg.
module mdd_queue #(
  parameter int unsigned Depth = mdd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mdd_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output mdd_pkg::job_t pop_job,
  output logic          pop_valid
);
  import mdd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/mdd_back.sv */
// Back end: bit-serial restoring divider, worst-drawdown tracking, output register.
// Depends on mdd_pkg and mdd_out_if.
module mdd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  mdd_pkg::job_t job,
  output logic          pop,
  mdd_out_if.source     results
);
  import mdd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam int unsigned StepW = $clog2(DD_W);

  logic [1:0]         state;
  logic [StepW-1:0]   step;
  logic [VALUE_W:0]   rem;
  logic [VALUE_W-1:0] divisor;
  logic [DD_W-1:0]    quo;
  logic               clear;
  logic               zero_peak;
  logic [DD_W-1:0]    worst;
  logic [DD_W-1:0]    worst_next;
  logic               out_valid;
  logic [DD_W-1:0]    out_cur;
  logic [DD_W-1:0]    out_worst;

  logic               ge;
  logic [VALUE_W:0]   rem_sub;
  logic               out_free;

  assign pop      = (state == S_IDLE) && job_valid;
  assign out_free = !out_valid || results.ready;

  assign ge      = rem >= {1'b0, divisor};
  assign rem_sub = ge ? rem - {1'b0, divisor} : rem;

  always_comb begin
    worst_next = clear ? '0 : worst;
    if (quo > worst_next) worst_next = quo;
  end

  assign results.valid            = out_valid;
  assign results.current_drawdown = out_cur;
  assign results.worst_drawdown   = out_worst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      worst     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result overrides the drain of the old one
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_DIV;
            step  <= '0;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == StepW'(DD_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            worst <= worst_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          rem       <= {1'b0, job.diff};
          divisor   <= job.peak;
          clear     <= job.clear;
          zero_peak <= job.peak == '0;
          quo       <= '0;
        end
      end
      S_DIV: begin
        rem <= {rem_sub[VALUE_W-1:0], 1'b0};
        // a zero peak reports zero drawdown
        quo <= zero_peak ? '0 : {quo[DD_W-2:0], ge};
      end
      S_OUT: begin
        if (out_free) begin
          out_cur   <= quo;
          out_worst <= worst_next;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/max_drawdown_tracker_top.sv */
// Top level of the maximum drawdown tracker: front end, job queue, divider back end.
// Depends on mdd_pkg, mdd_in_if, mdd_out_if, mdd_front, mdd_queue, mdd_back.
//
//  channel   role   fields                              notes
//  samples   sink   sample_value[31:0], series_start    one request per sample
//  results   source current_drawdown[16:0],             one result per sample,
//                   worst_drawdown[16:0]                Q1.16, 65536 = 1.0
//
// In the back end each sample is loaded as a job, runs 17 steps of the
// bit-serial restoring divider (one quotient bit a cycle), then has its result
// registered. The divider takes no new sample until the last result is registered.
// rst is synchronous: clears the peak, worst drawdown, queue and output valid.
// The front end keeps accepting while the queue has room; a stalled result
// holds in the output register and the divider waits behind it.
module max_drawdown_tracker_top #(
  parameter int unsigned QueueDepth = mdd_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  mdd_in_if.sink     samples,
  mdd_out_if.source  results
);
  import mdd_pkg::*;

  logic push;
  logic push_ready;
  logic pop;
  logic pop_valid;
  job_t push_job;
  job_t pop_job;

  mdd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  mdd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid)
  );

  mdd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job       (pop_job),
    .pop       (pop),
    .results   (results)
  );

  localparam logic [DD_W-1:0] DdOne = DD_W'(1) << FRAC_BITS;

  a_worst_covers_current: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.worst_drawdown >= results.current_drawdown)
    else $error("worst drawdown below current drawdown");

  a_drawdown_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.current_drawdown <= DdOne)
    else $error("drawdown above one");

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("divider took a job from an empty queue");

  a_accept_needs_room: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |-> push_ready)
    else $error("sample accepted while queue full");

endmodule
